FILE: rtl/rcfca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcfca_pkg
// Shared types, codes and constants of the remote-control frame checker.
// ----------------------------------------------------------------------------
package rcfca_pkg;

  localparam int unsigned OutChannels = 8;
  localparam int unsigned ChanW       = 11;
  localparam int unsigned CntW        = 15;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 15;

  localparam logic [7:0]        HDR_BYTE0 = 8'hAA;
  localparam logic [7:0]        HDR_BYTE1 = 8'hAF;
  localparam logic [ChanW-1:0]  CH_MIN    = 11'd1000;
  localparam logic [ChanW-1:0]  CH_MAX    = 11'd2000;
  localparam logic [CntW-1:0]   CNT_MAX   = 15'h7FFF;

  localparam logic [ChanW-1:0]  RST_ARM_LOW      = 11'd1150;
  localparam logic [ChanW-1:0]  RST_ARM_HIGH     = 11'd1800;
  localparam logic [7:0]        RST_HIGH_HOLD    = 8'd5;
  localparam logic [ChanW-1:0]  RST_DISARM_LEVEL = 11'd1200;
  localparam logic [ChanW-1:0]  RST_IDLE_LEVEL   = 11'd1020;
  localparam logic [CntW-1:0]   RST_IDLE_TIMEOUT = 15'd20000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ARM_LOW      = 3'd0,
    CFG_ARM_HIGH     = 3'd1,
    CFG_HIGH_HOLD    = 3'd2,
    CFG_DISARM_LEVEL = 3'd3,
    CFG_IDLE_LEVEL   = 3'd4,
    CFG_IDLE_TIMEOUT = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_WAIT_LOW     = 3'd0,
    PH_WAIT_HIGH    = 3'd1,
    PH_WAIT_RELEASE = 3'd2,
    PH_ARMED        = 3'd3,
    PH_EXIT         = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    LED_UNTOUCHED = 2'd0,
    LED_ON        = 2'd1,
    LED_FLASH     = 2'd2
  } led_e;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    logic [ChanW-1:0] arm_low;
    logic [ChanW-1:0] arm_high;
    logic [7:0]       high_hold;
    logic [ChanW-1:0] disarm_level;
    logic [ChanW-1:0] idle_level;
    logic [CntW-1:0]  idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic                        done;
    logic                        ok;
    logic [OutChannels-1:0][ChanW-1:0] chan;
  } frm_t;

  typedef struct packed {
    logic   armed;
    phase_e phase;
    led_e   led;
  } arm_t;

  function automatic chan_t clamp_channel(input logic [15:0] v);
    chan_t r;
    if (v < 16'(CH_MIN)) begin
      r = CH_MIN;
    end else if (v > 16'(CH_MAX)) begin
      r = CH_MAX;
    end else begin
      r = v[ChanW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rcfca_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcfca_cfg_regs
// Configuration register file for arming thresholds and timeouts.
// ----------------------------------------------------------------------------
module rcfca_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_en_i,
  input  wire logic [rcfca_pkg::CfgIdxW-1:0]   wr_idx_i,
  input  wire logic [rcfca_pkg::CfgDataW-1:0]  wr_data_i,
  output rcfca_pkg::cfg_t                      cfg_o
);

  rcfca_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (rcfca_pkg::cfg_idx_e'(wr_idx_i))
        rcfca_pkg::CFG_ARM_LOW:      cfg_d.arm_low      = wr_data_i[10:0];
        rcfca_pkg::CFG_ARM_HIGH:     cfg_d.arm_high     = wr_data_i[10:0];
        rcfca_pkg::CFG_HIGH_HOLD:    cfg_d.high_hold    = wr_data_i[7:0];
        rcfca_pkg::CFG_DISARM_LEVEL: cfg_d.disarm_level = wr_data_i[10:0];
        rcfca_pkg::CFG_IDLE_LEVEL:   cfg_d.idle_level   = wr_data_i[10:0];
        rcfca_pkg::CFG_IDLE_TIMEOUT: cfg_d.idle_timeout = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arm_low      <= rcfca_pkg::RST_ARM_LOW;
      cfg_q.arm_high     <= rcfca_pkg::RST_ARM_HIGH;
      cfg_q.high_hold    <= rcfca_pkg::RST_HIGH_HOLD;
      cfg_q.disarm_level <= rcfca_pkg::RST_DISARM_LEVEL;
      cfg_q.idle_level   <= rcfca_pkg::RST_IDLE_LEVEL;
      cfg_q.idle_timeout <= rcfca_pkg::RST_IDLE_TIMEOUT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/rcfca_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcfca_frame_parser
// Byte counter, checksum, header check and channel unpacking of one frame.
// ----------------------------------------------------------------------------
module rcfca_frame_parser #(
  parameter int unsigned FRAME_BYTES   = 32,
  parameter int unsigned CHANNEL_COUNT = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        frame_start_i,
  output rcfca_pkg::frm_t  frm_o
);

  localparam int unsigned PosW    = $clog2(FRAME_BYTES);
  localparam int unsigned ChIdxW  = $clog2(CHANNEL_COUNT);
  localparam int unsigned ChanLo  = 4;
  localparam int unsigned ChanEnd = ChanLo + 2 * CHANNEL_COUNT;
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);

  logic [PosW-1:0] pos_q, pos_d, pos_eff, rel;
  logic [7:0]      sum_q, sum_d, sum_eff;
  logic            hdr_q, hdr_d, hdr_eff;
  logic [7:0]      hold_q, hold_d;
  logic            last, ok, in_chan, pend_we;
  logic [ChIdxW-1:0] pend_idx;
  rcfca_pkg::chan_t pend_q [CHANNEL_COUNT];
  rcfca_pkg::chan_t chan_q [rcfca_pkg::OutChannels];
  rcfca_pkg::chan_t chan_d [rcfca_pkg::OutChannels];

  assign pos_eff = frame_start_i ? '0 : pos_q;
  assign sum_eff = frame_start_i ? '0 : sum_q;
  assign hdr_eff = frame_start_i ? 1'b1 : hdr_q;
  assign last    = (pos_eff == LastPos);
  assign ok      = last && (rx_byte_i == sum_eff) && hdr_eff;
  assign rel     = pos_eff - PosW'(ChanLo);
  assign in_chan = (pos_eff >= PosW'(ChanLo)) && (pos_eff < PosW'(ChanEnd));
  assign pend_idx = rel[ChIdxW:1];
  assign pend_we  = adv_i && !last && in_chan && rel[0];

  always_comb begin
    pos_d  = pos_eff + PosW'(1);
    sum_d  = sum_eff + rx_byte_i;
    hdr_d  = hdr_eff;
    hold_d = hold_q;
    if (pos_eff == PosW'(0) && rx_byte_i != rcfca_pkg::HDR_BYTE0) begin
      hdr_d = 1'b0;
    end
    if (pos_eff == PosW'(1) && rx_byte_i != rcfca_pkg::HDR_BYTE1) begin
      hdr_d = 1'b0;
    end
    if (in_chan && !rel[0]) begin
      hold_d = rx_byte_i;
    end
    if (last) begin
      pos_d = '0;
      sum_d = '0;
      hdr_d = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < rcfca_pkg::OutChannels; i++) begin
      chan_d[i] = chan_q[i];
      if (i < CHANNEL_COUNT && ok) begin
        chan_d[i] = pend_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      hdr_q  <= 1'b1;
      hold_q <= '0;
      for (int i = 0; i < rcfca_pkg::OutChannels; i++) begin
        chan_q[i] <= rcfca_pkg::CH_MIN;
      end
    end else if (adv_i) begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      hdr_q  <= hdr_d;
      hold_q <= hold_d;
      for (int i = 0; i < rcfca_pkg::OutChannels; i++) begin
        chan_q[i] <= chan_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_q[pend_idx] <= rcfca_pkg::clamp_channel({hold_q, rx_byte_i});
    end
  end

  always_comb begin
    frm_o.done = last;
    frm_o.ok   = ok;
    for (int i = 0; i < rcfca_pkg::OutChannels; i++) begin
      frm_o.chan[i] = chan_d[i];
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("frame position beyond last byte");

  a_channel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_q[2] >= rcfca_pkg::CH_MIN && chan_q[2] <= rcfca_pkg::CH_MAX &&
    chan_q[3] >= rcfca_pkg::CH_MIN && chan_q[3] <= rcfca_pkg::CH_MAX)
    else $error("stick channel outside clamp range");

endmodule
`default_nettype wire

FILE: rtl/rcfca_arming.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcfca_arming
// Throttle and yaw stick arming state machine, one step per good frame.
// ----------------------------------------------------------------------------
module rcfca_arming (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                run_i,
  input  wire logic                lock_cleared_i,
  input  rcfca_pkg::chan_t         thr_i,
  input  rcfca_pkg::chan_t         yaw_i,
  input  rcfca_pkg::cfg_t          cfg_i,
  output rcfca_pkg::arm_t          arm_o
);

  rcfca_pkg::phase_e phase_q, phase_d, phase_eff;
  rcfca_pkg::led_e   led_q, led_d;
  logic              armed_q, armed_d, armed_eff;
  logic [rcfca_pkg::CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic              thr_low, thr_high, thr_idle, cnt_over_hold, idle_expired;

  assign armed_eff = lock_cleared_i ? 1'b0 : armed_q;
  assign phase_eff = (thr_i < cfg_i.disarm_level && yaw_i < cfg_i.disarm_level) ?
                     rcfca_pkg::PH_EXIT : phase_q;
  assign cnt_inc   = (cnt_q < rcfca_pkg::CNT_MAX) ? cnt_q + 15'd1 : cnt_q;
  assign thr_low   = thr_i < cfg_i.arm_low;
  assign thr_high  = thr_i > cfg_i.arm_high;
  assign thr_idle  = thr_i < cfg_i.idle_level;
  assign cnt_over_hold = cnt_inc > 15'(cfg_i.high_hold);
  assign idle_expired  = (cnt_q > cfg_i.idle_timeout) || (cnt_q == rcfca_pkg::CNT_MAX);

  // next state
  always_comb begin
    phase_d = phase_q;
    if (run_i) begin
      case (phase_eff)
        rcfca_pkg::PH_WAIT_LOW:
          phase_d = thr_low ? rcfca_pkg::PH_WAIT_HIGH : phase_eff;
        rcfca_pkg::PH_WAIT_HIGH:
          phase_d = (thr_high && cnt_over_hold) ? rcfca_pkg::PH_WAIT_RELEASE : phase_eff;
        rcfca_pkg::PH_WAIT_RELEASE:
          phase_d = thr_low ? rcfca_pkg::PH_ARMED : phase_eff;
        rcfca_pkg::PH_ARMED: begin
          if (thr_idle) begin
            phase_d = idle_expired ? rcfca_pkg::PH_EXIT : phase_eff;
          end else begin
            phase_d = armed_eff ? phase_eff : rcfca_pkg::PH_EXIT;
          end
        end
        rcfca_pkg::PH_EXIT:
          phase_d = rcfca_pkg::PH_WAIT_LOW;
        default:
          phase_d = rcfca_pkg::PH_EXIT;
      endcase
    end
  end

  // counter, flag and led
  always_comb begin
    cnt_d   = cnt_q;
    armed_d = armed_q;
    led_d   = led_q;
    if (run_i) begin
      armed_d = armed_eff;
      case (phase_eff)
        rcfca_pkg::PH_WAIT_HIGH: begin
          if (thr_high) begin
            cnt_d = cnt_over_hold ? '0 : cnt_inc;
          end
        end
        rcfca_pkg::PH_WAIT_RELEASE: begin
          if (thr_low) begin
            armed_d = 1'b1;
            led_d   = rcfca_pkg::LED_ON;
          end
        end
        rcfca_pkg::PH_ARMED: begin
          if (thr_idle) begin
            cnt_d = cnt_inc;
          end else if (armed_eff) begin
            cnt_d = '0;
          end
        end
        rcfca_pkg::PH_EXIT: begin
          cnt_d   = '0;
          armed_d = 1'b0;
          led_d   = rcfca_pkg::LED_FLASH;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rcfca_pkg::PH_WAIT_LOW;
      led_q   <= rcfca_pkg::LED_UNTOUCHED;
      armed_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      led_q   <= led_d;
      armed_q <= armed_d;
      cnt_q   <= cnt_d;
    end
  end

  assign arm_o.armed = armed_d;
  assign arm_o.phase = phase_d;
  assign arm_o.led   = led_d;

  a_armed_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (phase_q == rcfca_pkg::PH_ARMED || phase_q == rcfca_pkg::PH_EXIT))
    else $error("armed outside armed or exiting phase");

  a_idle_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rcfca_pkg::PH_WAIT_LOW || phase_q == rcfca_pkg::PH_WAIT_RELEASE)
    |-> cnt_q == '0)
    else $error("frame counter not clear while waiting");

  a_led_on_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (led_q == rcfca_pkg::LED_ON && $past(led_q) != rcfca_pkg::LED_ON)
    |-> phase_q == rcfca_pkg::PH_ARMED)
    else $error("led switched on without arming");

endmodule
`default_nettype wire

FILE: rtl/rc_frame_check_and_arming_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc_frame_check_and_arming_unit
// Remote-control frame checker, channel unpacker and stick arming unit.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle while the result register is not stalled.
// The result of a frame is valid once its last byte has passed the input
//   register and then the result register.
// A stalled result register holds the whole pipe; a byte is taken meanwhile
//   only while the result register is free or being drained.
// Reset clears all control state, channels to 1000, thresholds to defaults.
module rc_frame_check_and_arming_unit #(
  parameter int unsigned FRAME_BYTES   = 32,
  parameter int unsigned CHANNEL_COUNT = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output wire logic                           s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]                     s_axis_tuser,   // [0] frame_start, [1] lock_cleared
  output wire logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [10:0] roll, [21:11] pitch, [32:22] throttle, [43:33] yaw, [54:44] aux_one,
  // [65:55] aux_two, [76:66] aux_three, [87:77] aux_four, [88] armed,
  // [91:89] arm_phase, [93:92] led_mode, [95:94] zero
  output wire logic [95:0]                    m_axis_tdata,
  output wire logic                           m_axis_tuser,   // [0] frame_ok
  input  wire logic                           cfg_valid_i,
  output wire logic                           cfg_ready_o,
  input  wire logic [rcfca_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rcfca_pkg::CfgDataW-1:0] cfg_data_i
);

  logic       en, adv;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q, in_lock_q;
  logic       out_valid_q, out_valid_d;
  logic       out_ok_q;
  logic [95:0] out_data_q, out_data_d;

  rcfca_pkg::cfg_t cfg;
  rcfca_pkg::frm_t frm;
  rcfca_pkg::arm_t arm;

  assign en  = !out_valid_q || m_axis_tready;
  assign adv = in_valid_q && en;

  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  rcfca_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  rcfca_frame_parser #(
    .FRAME_BYTES   (FRAME_BYTES),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .rx_byte_i     (in_byte_q),
    .frame_start_i (in_start_q),
    .frm_o         (frm)
  );

  rcfca_arming u_arming (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .run_i          (adv && frm.done && frm.ok),
    .lock_cleared_i (in_lock_q),
    .thr_i          (frm.chan[2]),
    .yaw_i          (frm.chan[3]),
    .cfg_i          (cfg),
    .arm_o          (arm)
  );

  always_comb begin
    out_data_d = '0;
    for (int i = 0; i < rcfca_pkg::OutChannels; i++) begin
      out_data_d[i*rcfca_pkg::ChanW +: rcfca_pkg::ChanW] = frm.chan[i];
    end
    out_data_d[88]    = arm.armed;
    out_data_d[91:89] = arm.phase;
    out_data_d[93:92] = arm.led;
    out_valid_d       = in_valid_q && frm.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q  <= s_axis_tvalid;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser[0];
      in_lock_q  <= s_axis_tuser[1];
      if (out_valid_d) begin
        out_ok_q   <= frm.ok;
        out_data_q <= out_data_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && in_valid_q && frm.done) |=> out_valid_q)
    else $error("last byte gave no result");

endmodule
`default_nettype wire

FILE: tb/rc_frame_check_and_arming_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_frame_check_and_arming_unit_tb
// Feeds remote-control frames byte by byte: directed frames covering header
// and checksum errors, channel clamping and a full arm and disarm sequence,
// then random frames mixed with broken and abandoned ones under several
// threshold settings and idle patterns. Every frame result is compared field
// by field with preset values or a cycle-free model of checker and arming logic.
// ----------------------------------------------------------------------------
module rc_frame_check_and_arming_unit_tb;
  import rcfca_pkg::*;

  localparam int FRAME_LEN  = 32;
  localparam int CHANS      = 8;
  localparam int CYCLE_CAP  = 200000;

  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_HDR0, FR_BAD_HDR1, FR_CUT} frame_kind_e;

  typedef struct packed {
    logic         ok;
    logic         armed;
    phase_e       phase;
    led_e         led;
    chan_t [7:0]  chan;
  } frame_res_t;

  typedef struct {
    frame_kind_e kind;
    logic [15:0] fill;
    logic [15:0] thr;
    logic [15:0] yaw;
    int          reps;
    logic        lock;
    logic        no_start;
    logic        typed;
    frame_res_t  res;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic        hold_req = 1'b0;

  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire [95:0]  m_axis_tdata;
  wire         m_axis_tuser;
  wire         cfg_ready_o;

  rc_frame_check_and_arming_unit DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state
  cfg_t        thresholds;
  logic [5:0]  byte_pos;
  logic [7:0]  byte_sum;
  logic        header_good;
  logic [7:0]  high_byte;
  chan_t       live_chans [CHANS];
  chan_t       staged_chans [CHANS];
  phase_e      arm_phase;
  logic [14:0] frame_count;
  logic        armed_now;
  led_e        led_now;

  frame_res_t  frame_results_due [$];
  plan_row_t   directed_plan [$];

  int src_idle = 0;
  int dst_idle = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int ok_seen = 0;
  int arm_events = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_taken = 1'b0;

  function automatic chan_t limit_channel(input logic [15:0] v);
    if (v < 16'd1000) return 11'd1000;
    if (v > 16'd2000) return 11'd2000;
    return v[10:0];
  endfunction

  task automatic reset_model();
    thresholds  = '{arm_low: 11'd1150, arm_high: 11'd1800, high_hold: 8'd5,
                    disarm_level: 11'd1200, idle_level: 11'd1020,
                    idle_timeout: 15'd20000};
    byte_pos    = '0;
    byte_sum    = '0;
    header_good = 1'b1;
    high_byte   = '0;
    for (int i = 0; i < CHANS; i++) begin
      live_chans[i]   = 11'd1000;
      staged_chans[i] = '0;
    end
    arm_phase   = PH_WAIT_LOW;
    frame_count = '0;
    armed_now   = 1'b0;
    led_now     = LED_UNTOUCHED;
  endtask

  task automatic bump_count();
    if (frame_count != 15'h7FFF) frame_count = frame_count + 15'd1;
  endtask

  task automatic advance_arming(input logic lock);
    chan_t       thr;
    chan_t       yw;
    logic [14:0] prev;
    thr = live_chans[2];
    yw  = live_chans[3];
    if (lock) armed_now = 1'b0;
    if (thr < thresholds.disarm_level && yw < thresholds.disarm_level) arm_phase = PH_EXIT;
    case (arm_phase)
      PH_WAIT_LOW: begin
        if (thr < thresholds.arm_low) arm_phase = PH_WAIT_HIGH;
      end
      PH_WAIT_HIGH: begin
        if (thr > thresholds.arm_high) begin
          bump_count();
          if (frame_count > 15'(thresholds.high_hold)) begin
            frame_count = '0;
            arm_phase   = PH_WAIT_RELEASE;
          end
        end
      end
      PH_WAIT_RELEASE: begin
        if (thr < thresholds.arm_low) begin
          armed_now = 1'b1;
          led_now   = LED_ON;
          arm_phase = PH_ARMED;
          arm_events++;
        end
      end
      PH_ARMED: begin
        if (thr < thresholds.idle_level) begin
          prev = frame_count;
          bump_count();
          if (prev > thresholds.idle_timeout || prev == 15'h7FFF) arm_phase = PH_EXIT;
        end else if (!armed_now) begin
          arm_phase = PH_EXIT;
        end else begin
          frame_count = '0;
        end
      end
      PH_EXIT: begin
        frame_count = '0;
        led_now     = LED_FLASH;
        armed_now   = 1'b0;
        arm_phase   = PH_WAIT_LOW;
      end
      default: arm_phase = PH_EXIT;
    endcase
  endtask

  task automatic predict_frame_result(input logic [7:0] b, input logic start,
                                      input logic lock, input logic use_typed,
                                      input frame_res_t typed);
    frame_res_t r;
    logic [5:0] p;
    int         k;
    if (start) begin
      byte_pos    = '0;
      byte_sum    = '0;
      header_good = 1'b1;
    end
    p = byte_pos;
    if (p < FRAME_LEN - 1) begin
      byte_sum = byte_sum + b;
      if (p == 0 && b != HDR_BYTE0) header_good = 1'b0;
      if (p == 1 && b != HDR_BYTE1) header_good = 1'b0;
      if (p >= 4 && p < 4 + 2 * CHANS) begin
        k = (p - 4) >> 1;
        if (((p - 4) & 1) == 0) high_byte = b;
        else staged_chans[k] = limit_channel({high_byte, b});
      end
      byte_pos = p + 6'd1;
    end else begin
      r.ok = (b == byte_sum) && header_good;
      if (r.ok) begin
        for (int i = 0; i < CHANS; i++) live_chans[i] = staged_chans[i];
        advance_arming(lock);
      end
      byte_pos    = '0;
      byte_sum    = '0;
      header_good = 1'b1;
      for (int i = 0; i < 8; i++) r.chan[i] = (i < CHANS) ? live_chans[i] : 11'd1000;
      r.armed = armed_now;
      r.phase = arm_phase;
      r.led   = led_now;
      frame_results_due.push_back(use_typed ? typed : r);
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic start, input logic lock,
                           input logic use_typed, input frame_res_t typed);
    while ($urandom_range(0, 99) < src_idle) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= {lock, start};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    bytes_sent++;
    predict_frame_result(b, start, lock, use_typed, typed);
  endtask

  task automatic send_frame(input frame_kind_e kind, input logic [7:0][15:0] raw,
                            input int n_bytes, input logic start_first,
                            input logic lock_last, input logic use_typed,
                            input frame_res_t typed);
    logic [7:0] fb [FRAME_LEN];
    logic [7:0] s;
    fb[0] = HDR_BYTE0;
    fb[1] = HDR_BYTE1;
    fb[2] = 8'($urandom);
    fb[3] = 8'($urandom);
    for (int k = 0; k < CHANS; k++) begin
      fb[4 + 2 * k] = raw[k][15:8];
      fb[5 + 2 * k] = raw[k][7:0];
    end
    for (int i = 4 + 2 * CHANS; i < FRAME_LEN - 1; i++) fb[i] = 8'($urandom);
    if (kind == FR_BAD_HDR0) fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
    if (kind == FR_BAD_HDR1) fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
    s = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) s = s + fb[i];
    fb[FRAME_LEN - 1] = (kind == FR_BAD_SUM) ? s + 8'($urandom_range(1, 255)) : s;
    for (int i = 0; i < n_bytes; i++) begin
      send_item(fb[i], (i == 0) ? start_first : 1'b0,
                (i == FRAME_LEN - 1) ? lock_last : 1'($urandom), use_typed, typed);
    end
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready_o);
    @(posedge clk);
    case (idx)
      CFG_ARM_LOW:      thresholds.arm_low      = val[10:0];
      CFG_ARM_HIGH:     thresholds.arm_high     = val[10:0];
      CFG_HIGH_HOLD:    thresholds.high_hold    = val[7:0];
      CFG_DISARM_LEVEL: thresholds.disarm_level = val[10:0];
      CFG_IDLE_LEVEL:   thresholds.idle_level   = val[10:0];
      CFG_IDLE_TIMEOUT: thresholds.idle_timeout = val[14:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int lo, input int hi, input int hold,
                                input int disarm, input int idle, input int tmo);
    wait_idle();
    cfg_write(CFG_ARM_LOW, 15'(lo));
    cfg_write(CFG_ARM_HIGH, 15'(hi));
    cfg_write(CFG_HIGH_HOLD, 15'(hold));
    cfg_write(CFG_DISARM_LEVEL, 15'(disarm));
    cfg_write(CFG_IDLE_LEVEL, 15'(idle));
    cfg_write(CFG_IDLE_TIMEOUT, 15'(tmo));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] below_level(input int lvl);
    if (lvl <= 1000) return 16'd1000;
    return 16'($urandom_range(1000, lvl - 1));
  endfunction

  function automatic logic [15:0] above_level(input int lvl);
    if (lvl >= 2000) return 16'd2000;
    return 16'($urandom_range(lvl + 1, 2000));
  endfunction

  function automatic logic [15:0] pick_throttle();
    case ($urandom_range(0, 9))
      0, 1, 2: return below_level(int'(thresholds.arm_low));
      3, 4, 5: return above_level(int'(thresholds.arm_high));
      6:       return below_level(int'(thresholds.idle_level));
      7: begin
        case ($urandom_range(0, 3))
          0:       return 16'(thresholds.arm_low);
          1:       return 16'(thresholds.arm_high);
          2:       return 16'(thresholds.idle_level);
          default: return 16'(thresholds.disarm_level);
        endcase
      end
      8:       return 16'($urandom_range(1000, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_yaw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 16'($urandom_range(1300, 2000));
    if (r < 95) return below_level(int'(thresholds.disarm_level));
    return 16'($urandom);
  endfunction

  task automatic run_random_frames(input int n_frames);
    logic [7:0][15:0] raw;
    frame_kind_e      kind;
    logic             start_first;
    int               r;
    for (int f = 0; f < n_frames; f++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 40)) begin
          send_item(8'($urandom), ($urandom_range(0, 9) == 0), 1'($urandom), 1'b0, '0);
        end
      end else begin
        kind = (r < 14) ? FR_CUT : (r < 20) ? FR_BAD_SUM :
               (r < 22) ? FR_BAD_HDR0 : (r < 24) ? FR_BAD_HDR1 : FR_GOOD;
        for (int k = 0; k < 8; k++) begin
          raw[k] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(900, 2100));
        end
        raw[2] = pick_throttle();
        raw[3] = pick_yaw();
        start_first = (byte_pos != 0) ? 1'b1 : ($urandom_range(0, 9) != 0);
        send_frame(kind, raw, (kind == FR_CUT) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN,
                   start_first, ($urandom_range(0, 24) == 0), 1'b0, '0);
      end
    end
  endtask

  function automatic plan_row_t mk_row(input frame_kind_e kind, input int fill, input int thr,
                                       input int yaw, input int reps, input logic lock,
                                       input logic no_start);
    plan_row_t row;
    row.kind     = kind;
    row.fill     = 16'(fill);
    row.thr      = 16'(thr);
    row.yaw      = 16'(yaw);
    row.reps     = reps;
    row.lock     = lock;
    row.no_start = no_start;
    row.typed    = 1'b0;
    row.res      = '0;
    return row;
  endfunction

  function automatic plan_row_t mk_typed(input plan_row_t row, input logic ok,
                                         input chan_t ch, input led_e led);
    row.typed     = 1'b1;
    row.res.ok    = ok;
    row.res.armed = 1'b0;
    row.res.phase = PH_WAIT_LOW;
    row.res.led   = led;
    row.res.chan  = {8{ch}};
    return row;
  endfunction

  always @(posedge clk) begin
    if (hold_req && hold_left == 0 && !hold_taken) begin
      hold_left  <= 400;
      hold_taken <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= dst_idle);
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned want, input int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in frame result %0d, %s: expected %0d, got %0d",
               results_seen, what, want, got);
    end
  endtask

  always @(negedge clk) begin
    frame_res_t got;
    frame_res_t want;
    if (rst_n && m_axis_tvalid && m_ready) begin
      got.ok    = m_axis_tuser;
      for (int i = 0; i < 8; i++) got.chan[i] = m_axis_tdata[11 * i +: 11];
      got.armed = m_axis_tdata[88];
      got.phase = phase_e'(m_axis_tdata[91:89]);
      got.led   = led_e'(m_axis_tdata[93:92]);
      if (got.ok) ok_seen++;
      if (frame_results_due.size() == 0) begin
        flag_mismatch("result with nothing outstanding", 0, 1);
      end else begin
        want = frame_results_due.pop_front();
        if (got.ok !== want.ok) flag_mismatch("frame_ok", want.ok, got.ok);
        for (int i = 0; i < 8; i++) begin
          if (got.chan[i] !== want.chan[i]) begin
            flag_mismatch($sformatf("channel %0d", i), want.chan[i], got.chan[i]);
          end
        end
        if (got.armed !== want.armed) flag_mismatch("armed", want.armed, got.armed);
        if (got.phase !== want.phase) flag_mismatch("arm_phase", want.phase, got.phase);
        if (got.led !== want.led) flag_mismatch("led_mode", want.led, got.led);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("rc_frame_check_and_arming_unit_tb failed");
      $finish;
    end
  end

  initial begin
    logic [7:0][15:0] raw;
    reset_model();
    // after reset: errors, clamping extremes, then a full arm and disarm
    directed_plan.push_back(mk_typed(mk_row(FR_BAD_SUM, 1500, 1500, 1500, 1, 0, 0),
                                     1'b0, 11'd1000, LED_UNTOUCHED));
    directed_plan.push_back(mk_typed(mk_row(FR_BAD_HDR0, 1500, 1500, 1500, 1, 0, 0),
                                     1'b0, 11'd1000, LED_UNTOUCHED));
    directed_plan.push_back(mk_typed(mk_row(FR_BAD_HDR1, 1500, 1500, 1500, 1, 0, 0),
                                     1'b0, 11'd1000, LED_UNTOUCHED));
    directed_plan.push_back(mk_typed(mk_row(FR_GOOD, 0, 0, 0, 1, 0, 0),
                                     1'b1, 11'd1000, LED_FLASH));
    directed_plan.push_back(mk_typed(mk_row(FR_GOOD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 0),
                                     1'b1, 11'd2000, LED_FLASH));
    directed_plan.push_back(mk_row(FR_GOOD, 999, 2001, 2000, 1, 0, 0));
    directed_plan.push_back(mk_row(FR_GOOD, 1000, 1999, 1001, 1, 0, 0));
    directed_plan.push_back(mk_row(FR_GOOD, 1500, 1100, 1500, 1, 0, 0));
    directed_plan.push_back(mk_row(FR_GOOD, 1500, 1900, 1500, 6, 0, 0));
    directed_plan.push_back(mk_row(FR_GOOD, 1500, 1100, 1500, 1, 0, 0));
    directed_plan.push_back(mk_row(FR_GOOD, 1500, 1010, 1500, 2, 0, 0));
    directed_plan.push_back(mk_row(FR_GOOD, 1500, 1500, 1500, 1, 0, 0));
    directed_plan.push_back(mk_row(FR_CUT, 1500, 1500, 1500, 1, 0, 0));
    directed_plan.push_back(mk_row(FR_GOOD, 1500, 1500, 1500, 1, 1, 0));
    directed_plan.push_back(mk_row(FR_GOOD, 1500, 1500, 1500, 1, 0, 1));
    directed_plan.push_back(mk_row(FR_GOOD, 1500, 1100, 1100, 1, 0, 0));
    directed_plan.push_back(mk_row(FR_BAD_SUM, 1500, 1100, 1500, 1, 1, 0));

    src_idle = 6;
    dst_idle = 76;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      raw = {directed_plan[i].fill, directed_plan[i].fill, directed_plan[i].fill,
             directed_plan[i].fill, directed_plan[i].yaw, directed_plan[i].thr,
             directed_plan[i].fill, directed_plan[i].fill};
      repeat (directed_plan[i].reps) begin
        send_frame(directed_plan[i].kind, raw,
                   (directed_plan[i].kind == FR_CUT) ? 12 : FRAME_LEN,
                   !directed_plan[i].no_start, directed_plan[i].lock,
                   directed_plan[i].typed, directed_plan[i].res);
      end
    end

    apply_settings(1150, 1800, 5, 1200, 1020, 20000);
    run_random_frames(12);
    apply_settings(1000, 1000, 0, 1000, 1000, 0);
    run_random_frames(12);

    src_idle = 76;
    dst_idle = 6;
    apply_settings(1300, 1600, 2, 1100, 1200, 3);
    run_random_frames(12);
    apply_settings(2000, 2000, 255, 2000, 2000, 32767);
    run_random_frames(12);

    src_idle = 0;
    dst_idle = 0;
    apply_settings($urandom_range(0, 32767), $urandom_range(0, 32767),
                   $urandom_range(0, 32767), $urandom_range(0, 32767),
                   $urandom_range(0, 32767), $urandom_range(0, 32767));
    hold_req <= 1'b1;
    run_random_frames(12);
    apply_settings(1150, 1800, 1, 1200, 1400, 0);
    run_random_frames(12);

    s_valid <= 1'b0;
    @(posedge clk);
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d frame bytes; checked %0d frame results, %0d of them accepted frames.",
             bytes_sent, results_seen, ok_seen);
    $display("Arming sequence completed %0d times across six threshold settings.", arm_events);
    if (mismatches == 0 && frame_results_due.size() == 0) begin
      $display("rc_frame_check_and_arming_unit_tb passed");
    end else begin
      $display("rc_frame_check_and_arming_unit_tb failed");
    end
    $finish;
  end

endmodule
